@@ src/jssc_pkg.sv @@
package jssc_pkg;

  // Motor direction codes, as shown on the result word
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CW   = 2'd1,
    MODE_CCW  = 2'd2
  } mode_t;

  // Register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_THR   = 3'd0,
    CFG_DOWN_THR = 3'd1,
    CFG_FASTEST  = 3'd2,
    CFG_SLOWEST  = 3'd3
  } cfg_idx_t;

  // Register reset values
  localparam int UP_THR_RESET   = 550;
  localparam int DOWN_THR_RESET = 500;
  localparam logic [7:0] FASTEST_RESET = 8'd2;
  localparam logic [7:0] SLOWEST_RESET = 8'd30;

  localparam int TICK_W  = 8;
  localparam int PHASE_W = 3;
  localparam int COIL_W  = 4;
  localparam int PER_W   = 10;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic commit;
  } jssc_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic div_done;
    logic out_free;
  } jssc_stat_t;

  // Half-step coil sequence
  function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

@@ src/joystick_stepper_speed_control_top.sv @@
// A sample passes through setup, the radix-4 divider steps and commit; the
// result word is registered at commit.
// The shared divider takes one sample at a time; the next sample is taken
// while the result word waits, and a stalled word holds the next commit.
// Reset (rst_n low, synchronous): idle mode, tick count, phase and coils zero,
// registers at their defaults; no clearing pass.
module joystick_stepper_speed_control_top import jssc_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COIL_W-1:0]      out_coils,
  output logic                   out_stepped,
  output logic [1:0]             out_direction,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata
);

  jssc_cmd_t  cmd;
  jssc_stat_t stat;

  jssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  jssc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_coils     (out_coils),
    .out_stepped   (out_stepped),
    .out_direction (out_direction),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

endmodule

@@ src/jssc_ctrl.sv @@
module jssc_ctrl import jssc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  jssc_stat_t stat,
  output jssc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid && !in_stall_r;
    cmd.setup    = (state_r == ST_SETUP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.commit   = (state_r == ST_DONE) && stat.out_free;
  end

  // Advance the sequencer; hold the input stalled while a word is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.load) begin
            state_r    <= ST_SETUP;
            in_stall_r <= 1'b1;
          end
        end
        ST_SETUP: state_r <= ST_DIV;
        ST_DIV: begin
          if (stat.div_done) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (stat.out_free) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall = in_stall_r;

  a_load_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SETUP)
    else $error("accepted word did not start setup");

  a_commit_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall)
    else $error("input still stalled after commit");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> in_stall)
    else $error("input open during division");

endmodule

@@ src/jssc_dp.sv @@
module jssc_dp import jssc_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  jssc_cmd_t              cmd,
  output jssc_stat_t             stat,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COIL_W-1:0]      out_coils,
  output logic                   out_stepped,
  output logic [1:0]             out_direction,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int NUMW   = SB + TICK_W;
  localparam int ITER   = (NUMW + 1) / 2;
  localparam int DIVW   = 2 * ITER;
  localparam int CNT_W  = $clog2(ITER);
  localparam logic [SB-1:0] FULL = {SB{1'b1}};
  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ITER - 1);

  // Configuration registers
  logic [SB-1:0]     up_r, down_r;
  logic [TICK_W-1:0] fast_r, slow_r;

  // Motor state
  mode_t              mode_r, pend_mode_r, mode_nxt;
  logic [TICK_W-1:0]  tick_r;
  logic [PHASE_W-1:0] phase_r;
  logic [COIL_W-1:0]  coil_r;

  // Division state
  logic [SB-1:0]    sample_r;
  logic [SB-1:0]    den_r, rem_r;
  logic [DIVW-1:0]  nq_r;
  logic [CNT_W-1:0] cnt_r;
  logic             span_neg_r;

  // Result word
  logic              out_valid_r;
  logic [COIL_W-1:0] out_coils_r;
  logic              out_stepped_r;
  logic [1:0]        out_dir_r;

  assign cfg_ready = 1'b1;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r   <= SB'(UP_THR_RESET);
      down_r <= SB'(DOWN_THR_RESET);
      fast_r <= FASTEST_RESET;
      slow_r <= SLOWEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UP_THR:   up_r   <= cfg_wdata;
        CFG_DOWN_THR: down_r <= cfg_wdata;
        CFG_FASTEST:  fast_r <= cfg_wdata[TICK_W-1:0];
        CFG_SLOWEST:  slow_r <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Setup: next mode, map numerator and divisor
  logic                above, below;
  logic [SB-1:0]       diff, den;
  logic [TICK_W:0]     span, span_abs;
  logic [NUMW-1:0]     prod;

  always_comb begin
    above = sample_r > up_r;
    below = sample_r < down_r;
    case (mode_r)
      MODE_CW:  mode_nxt = above ? MODE_CW : MODE_IDLE;
      MODE_CCW: mode_nxt = below ? MODE_CCW : MODE_IDLE;
      default: begin
        mode_nxt = MODE_IDLE;
        if (above) mode_nxt = MODE_CW;
        if (below) mode_nxt = MODE_CCW;
      end
    endcase
    if (mode_nxt == MODE_CW) begin
      diff = sample_r - up_r;
      den  = FULL - up_r;
    end else begin
      diff = sample_r;
      den  = down_r;
    end
    span     = {1'b0, slow_r} - {1'b0, fast_r};
    span_abs = span[TICK_W] ? (~span + 1'b1) : span;
    prod     = NUMW'(diff) * NUMW'(span_abs[TICK_W-1:0]);
  end

  // Two restoring division steps per cycle
  logic [SB:0]   r1, r2;
  logic [SB-1:0] r1s, r2s;
  logic          ge1, ge2;

  always_comb begin
    r1  = {rem_r, nq_r[DIVW-1]};
    ge1 = r1 >= {1'b0, den_r};
    r1s = ge1 ? SB'(r1 - {1'b0, den_r}) : r1[SB-1:0];
    r2  = {r1s, nq_r[DIVW-2]};
    ge2 = r2 >= {1'b0, den_r};
    r2s = ge2 ? SB'(r2 - {1'b0, den_r}) : r2[SB-1:0];
  end

  // Finish: period, tick and phase update
  logic [TICK_W-1:0]  q;
  logic [PER_W-1:0]   term, base, per_raw, per;
  logic [TICK_W-1:0]  tick_inc;
  logic               hit;

  always_comb begin
    q    = nq_r[TICK_W-1:0];
    term = span_neg_r ? (~{2'b00, q} + 1'b1) : {2'b00, q};
    if (pend_mode_r == MODE_CW) begin
      base    = {2'b00, slow_r};
      per_raw = base - term;
    end else begin
      base    = {2'b00, fast_r};
      per_raw = base + term;
    end
    if (den_r == '0) per_raw = {2'b00, fast_r};
    // clamp periods below one
    if (per_raw[PER_W-1] || per_raw == '0) per = PER_W'(1);
    else                                   per = per_raw;
    tick_inc = (tick_r == '1) ? tick_r : tick_r + 1'b1;
    hit      = {2'b00, tick_inc} >= per;
  end

  // Hold sample, run division
  always_ff @(posedge clk) begin
    if (cmd.load) sample_r <= in_sample;
    if (cmd.setup) begin
      pend_mode_r <= mode_nxt;
      den_r       <= den;
      rem_r       <= '0;
      nq_r        <= DIVW'(prod);
      span_neg_r  <= span[TICK_W];
    end else if (cmd.div_step) begin
      rem_r <= r2s;
      nq_r  <= {nq_r[DIVW-3:0], ge1, ge2};
    end
  end

  // Iteration count
  always_ff @(posedge clk) begin
    if (!rst_n)             cnt_r <= '0;
    else if (cmd.setup)     cnt_r <= '0;
    else if (cmd.div_step)  cnt_r <= cnt_r + 1'b1;
  end

  // Commit motor state and the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      tick_r      <= '0;
      phase_r     <= '0;
      coil_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        mode_r      <= pend_mode_r;
        out_valid_r <= 1'b1;
        out_dir_r   <= pend_mode_r;
        if (pend_mode_r == MODE_IDLE) begin
          tick_r        <= '0;
          out_stepped_r <= 1'b0;
          out_coils_r   <= coil_r;
        end else if (hit) begin
          tick_r        <= '0;
          coil_r        <= half_step(phase_r);
          out_coils_r   <= half_step(phase_r);
          out_stepped_r <= 1'b1;
          phase_r       <= (pend_mode_r == MODE_CW) ? phase_r + 1'b1 : phase_r - 1'b1;
        end else begin
          tick_r        <= tick_inc;
          out_stepped_r <= 1'b0;
          out_coils_r   <= coil_r;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.div_done = cmd.div_step && (cnt_r == LAST_ITER);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_coils     = out_coils_r;
  assign out_stepped   = out_stepped_r;
  assign out_direction = out_dir_r;

  a_commit_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result word");

  a_phase_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(phase_r))
    else $error("phase moved outside commit");

  a_step_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stepped) |-> (out_direction != MODE_IDLE))
    else $error("step reported while idle");

endmodule
